// ===== sv/vertex_light_depth_cue_core_macros.svh =====
// Assertion macros shared by the lighting core's checker.
`ifndef VERTEX_LIGHT_DEPTH_CUE_CORE_MACROS_SVH
`define VERTEX_LIGHT_DEPTH_CUE_CORE_MACROS_SVH

// Clocked property that is ignored while reset is asserted.
`define VLDC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked property that must also hold during reset.
`define VLDC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== sv/vldc_pkg.sv =====
// Shared widths, shifts and register indexes for the vertex lighting core.
package vldc_pkg;

  localparam int unsigned NormalW  = 16;
  localparam int unsigned DirW     = 17;
  localparam int unsigned DirPackW = 3 * DirW;
  localparam int unsigned WeightW  = 14;
  localparam int unsigned WeightPackW = 3 * WeightW;
  localparam int unsigned AmbientPackW = 24;
  localparam int unsigned DepthW   = 31;
  localparam int unsigned DotW     = 17;
  localparam int unsigned ChanW    = 5;
  localparam int unsigned ColorW   = 3 * ChanW;
  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned CfgDataW = 51;

  localparam int unsigned DotShift     = 16;
  localparam int unsigned AmbientShift = 13;
  localparam int unsigned ChanShift    = 16 + 3;
  localparam int unsigned FadeShift    = 14;
  localparam int unsigned FadeFull     = 2048;
  localparam int unsigned ChanMax      = 'h1f;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SUN_DIR   = 4'd0,
    CFG_OMNI_DIR  = 4'd1,
    CFG_DYN_DIR   = 4'd2,
    CFG_RED_WGT   = 4'd3,
    CFG_GREEN_WGT = 4'd4,
    CFG_BLUE_WGT  = 4'd5,
    CFG_AMBIENT   = 4'd6,
    CFG_CUE_START = 4'd7
  } cfg_index_e;

  typedef logic signed [NormalW-1:0] normal_t;
  typedef logic [DotW-1:0]           dot_t;

endpackage

// ===== sv/vertex_light_depth_cue_core.sv =====
// Top level of the three-light diffuse vertex lighting core with depth cueing.
//
//   Channel   Handshake                    Payload
//   --------  ---------------------------  ----------------------------------------
//   vertex    start / busy                 normal_x_i, normal_y_i, normal_z_i,
//                                          view_depth_i
//   result    result_strobe_o (one cycle)  color555_o
//   config    cfg_valid_i / cfg_ready_o    cfg_index_i, cfg_data_i
//
// One vertex word is taken every cycle; busy never rises and cfg_ready_o is
// always high. Each vertex leaves as one result word after it passes these stages:
// two stages for the light dot products, one for the weight multiplies, one
// for the channel sums and clamps, and one for the depth-cue scale and
// packing. The receiver cannot stall, so the pipeline always moves.
// Reset clears the valid bits and all configuration registers to zero.
module vertex_light_depth_cue_core
  import vldc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  normal_t             normal_x_i,
  input  normal_t             normal_y_i,
  input  normal_t             normal_z_i,
  input  logic [DepthW-1:0]   view_depth_i,
  output logic                result_strobe_o,
  output logic [ColorW-1:0]   color555_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned DiffShW  = DepthW - DotShift;   // depth difference >> 16
  localparam int unsigned ScaleW   = 12;                  // scale 1..2048
  localparam int unsigned WProdW   = WeightW + DotW;
  localparam int unsigned ChSumW   = WProdW + 2;
  localparam int unsigned ChShW    = ChSumW - ChanShift;
  localparam int unsigned FadeProdW = ChanW + ScaleW;
  // (c << 3) * v >> 14 is the same as c * v >> 11.
  localparam int unsigned FadeNetShift = FadeShift - 3;

  // ---------------------------------------------------------------------
  // Configuration registers. Writes must arrive only while the pipeline is idle;
  // the block itself does not enforce this. The stages read these directly.
  // ---------------------------------------------------------------------
  logic [DirPackW-1:0]     dir_q [3];
  logic [WeightPackW-1:0]  wgt_q [3];
  logic [AmbientPackW-1:0] ambient_q;
  logic [DepthW-1:0]       cue_start_q;

  assign cfg_ready_o = 1'b1;
  assign busy        = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q[0]    <= '0;
      dir_q[1]    <= '0;
      dir_q[2]    <= '0;
      wgt_q[0]    <= '0;
      wgt_q[1]    <= '0;
      wgt_q[2]    <= '0;
      ambient_q   <= '0;
      cue_start_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_SUN_DIR:   dir_q[0]    <= cfg_data_i[DirPackW-1:0];
        CFG_OMNI_DIR:  dir_q[1]    <= cfg_data_i[DirPackW-1:0];
        CFG_DYN_DIR:   dir_q[2]    <= cfg_data_i[DirPackW-1:0];
        CFG_RED_WGT:   wgt_q[0]    <= cfg_data_i[WeightPackW-1:0];
        CFG_GREEN_WGT: wgt_q[1]    <= cfg_data_i[WeightPackW-1:0];
        CFG_BLUE_WGT:  wgt_q[2]    <= cfg_data_i[WeightPackW-1:0];
        CFG_AMBIENT:   ambient_q   <= cfg_data_i[AmbientPackW-1:0];
        CFG_CUE_START: cue_start_q <= cfg_data_i[DepthW-1:0];
        default: begin
          // Indexes past the register list are dropped.
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Valid bits, one per stage. Stage five drives the result strobe.
  // ---------------------------------------------------------------------
  logic [4:0] vld_q;
  logic       accept;

  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[3:0], accept};
    end
  end

  // ---------------------------------------------------------------------
  // Stages one and two: the three light dot products.
  // ---------------------------------------------------------------------
  dot_t dot [3];

  for (genvar l = 0; l < 3; l++) begin : g_light
    vldc_dot u_dot (
      .clk_i      (clk_i),
      .normal_x_i (normal_x_i),
      .normal_y_i (normal_y_i),
      .normal_z_i (normal_z_i),
      .dir_i      (dir_q[l]),
      .dot_o      (dot[l])
    );
  end

  // Depth cue runs alongside. Stage one forms the distance past the start,
  // stage two turns it into the scale factor and decides whether it is zero.
  logic              cue1_d, cue1_q;
  logic [DiffShW-1:0] dsh1_d, dsh1_q;
  logic [DepthW-1:0] diff;

  always_comb begin
    diff   = view_depth_i - cue_start_q;
    cue1_d = view_depth_i > cue_start_q;
    dsh1_d = diff[DotShift +: DiffShW];
  end

  logic              fade2_d, zero2_d;
  logic [ScaleW-1:0] scale2_d;
  logic [DiffShW-1:0] full_ext;

  always_comb begin
    full_ext = DiffShW'(FadeFull);
    zero2_d  = cue1_q && (dsh1_q >= full_ext);
    fade2_d  = cue1_q && (dsh1_q < full_ext);
    scale2_d = ScaleW'(full_ext - dsh1_q);
  end

  logic [3:0]        fade_q;   // stages two to four
  logic [3:0]        zero_q;
  logic [ScaleW-1:0] scale_q [2:4];

  always_ff @(posedge clk_i) begin
    cue1_q     <= cue1_d;
    dsh1_q     <= dsh1_d;
    fade_q     <= {fade_q[2:1], fade2_d, 1'b0};
    zero_q     <= {zero_q[2:1], zero2_d, 1'b0};
    scale_q[2] <= scale2_d;
    scale_q[3] <= scale_q[2];
    scale_q[4] <= scale_q[3];
  end

  // ---------------------------------------------------------------------
  // Stage three: each channel weight times each light dot.
  // ---------------------------------------------------------------------
  logic [WProdW-1:0] wprod_d [3][3];
  logic [WProdW-1:0] wprod_q [3][3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      for (int l = 0; l < 3; l++) begin
        wprod_d[c][l] = WProdW'(wgt_q[c][l*WeightW +: WeightW]) * WProdW'(dot[l]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    wprod_q <= wprod_d;
  end

  // ---------------------------------------------------------------------
  // Stage four: ambient plus the weighted dots, shifted and saturated.
  // Channel 0 is red (ambient bits 23..16), 1 green, 2 blue.
  // ---------------------------------------------------------------------
  logic [ChSumW-1:0] chsum [3];
  logic [ChShW-1:0]  chsh  [3];
  logic [ChanW-1:0]  chan4_d [3];
  logic [ChanW-1:0]  chan4_q [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      chsum[c] = (ChSumW'(ambient_q[(2-c)*8 +: 8]) << AmbientShift)
               + ChSumW'(wprod_q[c][0]) + ChSumW'(wprod_q[c][1])
               + ChSumW'(wprod_q[c][2]);
      chsh[c]  = chsum[c][ChanShift +: ChShW];
      if (chsh[c] > ChShW'(ChanMax)) begin
        chan4_d[c] = ChanW'(ChanMax);
      end else begin
        chan4_d[c] = chsh[c][ChanW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    chan4_q <= chan4_d;
  end

  // ---------------------------------------------------------------------
  // Stage five: depth-cue scale and RGB555 packing. The scaled channel never
  // exceeds 31, since the scale is at most 2048.
  // ---------------------------------------------------------------------
  logic [FadeProdW-1:0] fprod [3];
  logic [ChanW-1:0]     chan5 [3];
  logic [ColorW-1:0]    color_d, color_q;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      fprod[c] = FadeProdW'(chan4_q[c]) * FadeProdW'(scale_q[4]);
      if (zero_q[3]) begin
        chan5[c] = '0;
      end else if (fade_q[3]) begin
        chan5[c] = fprod[c][FadeNetShift +: ChanW];
      end else begin
        chan5[c] = chan4_q[c];
      end
    end
    color_d = {chan5[0], chan5[1], chan5[2]};
  end

  always_ff @(posedge clk_i) begin
    color_q <= color_d;
  end

  assign result_strobe_o = vld_q[4];
  assign color555_o      = color_q;

endmodule

// ===== sv/vldc_dot.sv =====
// Two-stage dot product of a normal with one packed light direction, clamped at zero.
module vldc_dot
  import vldc_pkg::*;
(
  input  logic                clk_i,
  input  normal_t             normal_x_i,
  input  normal_t             normal_y_i,
  input  normal_t             normal_z_i,
  input  logic [DirPackW-1:0] dir_i,
  output dot_t                dot_o
);

  localparam int unsigned ProdW = NormalW + DirW;
  localparam int unsigned SumW  = ProdW + 2;

  logic signed [ProdW-1:0] px_d, py_d, pz_d;
  logic signed [ProdW-1:0] px_q, py_q, pz_q;
  logic signed [SumW-1:0]  sum;
  dot_t                    dot_d, dot_q;

  always_comb begin
    px_d = ProdW'($signed(normal_x_i)) * ProdW'($signed(dir_i[0*DirW +: DirW]));
    py_d = ProdW'($signed(normal_y_i)) * ProdW'($signed(dir_i[1*DirW +: DirW]));
    pz_d = ProdW'($signed(normal_z_i)) * ProdW'($signed(dir_i[2*DirW +: DirW]));
  end

  // The sum of three products stays below 2^33, so bits above the shifted
  // field are zero whenever the sum is not negative.
  always_comb begin
    sum = SumW'(px_q) + SumW'(py_q) + SumW'(pz_q);
    if (sum[SumW-1]) begin
      dot_d = '0;
    end else begin
      dot_d = sum[DotShift +: DotW];
    end
  end

  always_ff @(posedge clk_i) begin
    px_q  <= px_d;
    py_q  <= py_d;
    pz_q  <= pz_d;
    dot_q <= dot_d;
  end

  assign dot_o = dot_q;

endmodule

// ===== sv/vldc_checker.sv =====
// Port-level checker for the vertex lighting core, with its bind statement.
`include "vertex_light_depth_cue_core_macros.svh"

module vldc_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic result_strobe_o,
  input logic cfg_ready_o
);

  // Every accepted vertex is followed by its result strobe.
  `VLDC_ASSERT(a_result_follows, (start && !busy) |-> ##5 result_strobe_o, "missing result")

  // No result appears unless a vertex was accepted earlier.
  `VLDC_ASSERT(a_no_spurious, result_strobe_o |-> $past(start && !busy, 5), "spurious result")

  // Neither the vertex side nor the configuration side is ever held off.
  `VLDC_ASSERT_ALWAYS(a_never_stalls, !busy && cfg_ready_o, "input side stalled")

endmodule

bind vertex_light_depth_cue_core vldc_checker u_vldc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start           (start),
  .busy            (busy),
  .result_strobe_o (result_strobe_o),
  .cfg_ready_o     (cfg_ready_o)
);
